FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the spring force pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define SBF_ASSERT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define SBF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/sbf_pkg.sv
// Types and constants of the spring and bungee force pipeline.
`default_nettype none
package sbf_pkg;

  localparam int NUM_AXES   = 3;
  localparam int D_W        = 33;
  localparam int SUM_W      = 66;
  localparam int LEN_W      = 33;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SPRING_CONST  = 3'd0;
  localparam reg_idx_t REG_REST_LENGTH   = 3'd1;
  localparam reg_idx_t REG_BUNGEE_MODE   = 3'd2;
  localparam reg_idx_t REG_ANCHORED_MODE = 3'd3;
  localparam reg_idx_t REG_ANCHOR_X      = 3'd4;
  localparam reg_idx_t REG_ANCHOR_Y      = 3'd5;
  localparam reg_idx_t REG_ANCHOR_Z      = 3'd6;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic signed [31:0] other_z;
  } sbf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               applied;
  } sbf_out_t;

  // Separation magnitudes and signs that ride along the square root stages.
  typedef struct packed {
    logic [NUM_AXES-1:0][D_W-1:0] ad;
    logic [NUM_AXES-1:0]          dpos;
    logic [NUM_AXES-1:0]          dneg;
  } sbf_axes_t;

  // Per-item decisions that ride along the divider stages.
  typedef struct packed {
    logic                slack;
    logic                zero;
    logic                negx;
    logic [NUM_AXES-1:0] dpos;
    logic [NUM_AXES-1:0] dneg;
  } sbf_flags_t;

endpackage
`default_nettype wire

FILE: rtl/core/spring_bungee_force.sv
// Pipelined Hooke's-law spring and bungee force unit with an APB register port.
`default_nettype none
`include "assert_macros.svh"
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   src     | in        | src_valid/src_stall  | sbf_in_t: positions
//   res     | out       | res_valid/res_stall  | sbf_out_t: force and applied
//   apb     | in        | psel/penable/pwrite  | spring, rest, modes, anchor
//
// One transaction enters per clock cycle and one result leaves per cycle
// while the result is not stalled. The pipeline has three front stages,
// 33 stages of the bit-per-stage square root and FRAC_BITS + 1 stages of the
// bit-per-stage divider, then the product and saturation stages.
// Reset clears the valid bits and sets the registers to their reset values.
// A stalled result freezes every stage, so the pipeline holds its contents
// and src_stall rises until the result is taken.
module spring_bungee_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sbf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         src_valid,
  output logic                         src_stall,
  input  sbf_pkg::sbf_in_t             src_data,
  output logic                         res_valid,
  input  logic                         res_stall,
  output sbf_pkg::sbf_out_t            res_data
);
  import sbf_pkg::*;

  localparam int Q_W        = FRAC_BITS + 1;
  localparam int MAG_W      = 64 - FRAC_BITS;
  localparam int PROD_W     = MAG_W + Q_W;
  localparam int SHR_W      = PROD_W - FRAC_BITS;
  localparam int SQ_STAGES  = LEN_W;
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int SQ_LAST    = SQ_STAGES - 1;
  localparam int DIV_LAST   = DIV_STAGES - 1;

  // Configuration registers.
  logic [30:0]        spring_const;
  logic [30:0]        rest_length;
  logic               bungee_mode;
  logic               anchored_mode;
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  logic signed [31:0] anchor_z;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_const  <= 31'd65536;
      rest_length   <= 31'd65536;
      bungee_mode   <= 1'b0;
      anchored_mode <= 1'b0;
      anchor_x      <= '0;
      anchor_y      <= '0;
      anchor_z      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SPRING_CONST:  spring_const  <= pwdata[30:0];
        REG_REST_LENGTH:   rest_length   <= pwdata[30:0];
        REG_BUNGEE_MODE:   bungee_mode   <= pwdata[0];
        REG_ANCHORED_MODE: anchored_mode <= pwdata[0];
        REG_ANCHOR_X:      anchor_x      <= pwdata;
        REG_ANCHOR_Y:      anchor_y      <= pwdata;
        REG_ANCHOR_Z:      anchor_z      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPRING_CONST:  prdata = {1'b0, spring_const};
      REG_REST_LENGTH:   prdata = {1'b0, rest_length};
      REG_BUNGEE_MODE:   prdata = {31'd0, bungee_mode};
      REG_ANCHORED_MODE: prdata = {31'd0, anchored_mode};
      REG_ANCHOR_X:      prdata = anchor_x;
      REG_ANCHOR_Y:      prdata = anchor_y;
      REG_ANCHOR_Z:      prdata = anchor_z;
      default:           prdata = '0;
    endcase
  end

  // The whole pipeline advances together unless the result is held.
  logic en;
  assign en        = !(res_valid && res_stall);
  assign src_stall = !en;

  // Stage 0: separation d = pos - other or anchor, as magnitude and sign.
  logic signed [31:0] pos_a [NUM_AXES];
  logic signed [31:0] oth_a [NUM_AXES];
  logic [D_W-1:0]     d_c   [NUM_AXES];
  sbf_axes_t          ax0_c;

  always_comb begin
    pos_a[0] = src_data.pos_x;
    pos_a[1] = src_data.pos_y;
    pos_a[2] = src_data.pos_z;
    oth_a[0] = anchored_mode ? anchor_x : src_data.other_x;
    oth_a[1] = anchored_mode ? anchor_y : src_data.other_y;
    oth_a[2] = anchored_mode ? anchor_z : src_data.other_z;
    for (int i = 0; i < NUM_AXES; i++) begin
      d_c[i]         = {pos_a[i][31], pos_a[i]} - {oth_a[i][31], oth_a[i]};
      ax0_c.dneg[i]  = d_c[i][D_W-1];
      ax0_c.dpos[i]  = !d_c[i][D_W-1] && (d_c[i] != '0);
      ax0_c.ad[i]    = d_c[i][D_W-1] ? (~d_c[i] + 1'b1) : d_c[i];
    end
  end

  logic      s0_v, s1_v, s2_v;
  sbf_axes_t s0_ax, s1_ax, s2_ax;
  logic [SUM_W-1:0] s1_sq [NUM_AXES];
  logic [SUM_W-1:0] s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s0_v <= src_valid;
      s1_v <= s0_v;
      s2_v <= s1_v;
    end
  end

  // Stage 1 squares each magnitude, stage 2 sums the three squares.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax <= ax0_c;
      s1_ax <= s0_ax;
      s2_ax <= s1_ax;
      for (int i = 0; i < NUM_AXES; i++) begin
        s1_sq[i] <= s0_ax.ad[i] * s0_ax.ad[i];
      end
      s2_sum <= s1_sq[0] + s1_sq[1] + s1_sq[2];
    end
  end

  // Square root, one result bit per stage from the top. The remainder
  // holds sum - res^2; a bit is kept when the remainder covers the growth.
  logic             sr_v   [SQ_STAGES];
  logic [SUM_W-1:0] sr_rem [SQ_STAGES];
  logic [LEN_W-1:0] sr_res [SQ_STAGES];
  sbf_axes_t        sr_ax  [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int B = LEN_W - 1 - k;
    logic             v_in;
    logic [SUM_W-1:0] rem_in;
    logic [LEN_W-1:0] res_in;
    sbf_axes_t        ax_in;
    logic [SUM_W+1:0] trial;

    if (k == 0) begin : g_first
      assign v_in   = s2_v;
      assign rem_in = s2_sum;
      assign res_in = '0;
      assign ax_in  = s2_ax;
    end else begin : g_next
      assign v_in   = sr_v[k-1];
      assign rem_in = sr_rem[k-1];
      assign res_in = sr_res[k-1];
      assign ax_in  = sr_ax[k-1];
    end

    assign trial = ((SUM_W+2)'(res_in) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[k] <= 1'b0;
      end else if (en) begin
        sr_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_ax[k] <= ax_in;
        if ({2'b00, rem_in} >= trial) begin
          sr_rem[k] <= rem_in - trial[SUM_W-1:0];
          sr_res[k] <= res_in | (LEN_W'(1) << B);
        end else begin
          sr_rem[k] <= rem_in;
          sr_res[k] <= res_in;
        end
      end
    end
  end

  // Divider stage 0: extension and mode decisions, integer bit of |d|/len.
  logic [LEN_W-1:0] len_c;
  logic [LEN_W-1:0] rest_c;
  logic             ge_c;
  sbf_flags_t       fl0_c;
  logic [LEN_W-1:0] ext_c;
  logic [NUM_AXES-1:0][D_W-1:0] rem0_c;
  logic [NUM_AXES-1:0][Q_W-1:0] q0_c;

  always_comb begin
    len_c      = sr_res[SQ_LAST];
    rest_c     = {2'b00, rest_length};
    ge_c       = len_c >= rest_c;
    ext_c      = ge_c ? (len_c - rest_c) : (rest_c - len_c);
    fl0_c.slack = bungee_mode && (len_c <= rest_c);
    fl0_c.zero  = len_c == '0;
    fl0_c.negx  = !ge_c && anchored_mode;
    fl0_c.dpos  = sr_ax[SQ_LAST].dpos;
    fl0_c.dneg  = sr_ax[SQ_LAST].dneg;
    for (int i = 0; i < NUM_AXES; i++) begin
      q0_c[i]   = '0;
      q0_c[i][0] = sr_ax[SQ_LAST].ad[i] >= len_c;
      rem0_c[i] = q0_c[i][0] ? (sr_ax[SQ_LAST].ad[i] - len_c) : sr_ax[SQ_LAST].ad[i];
    end
  end

  logic                         dv_v   [DIV_STAGES];
  logic [LEN_W-1:0]             dv_len [DIV_STAGES];
  logic [NUM_AXES-1:0][D_W-1:0] dv_rem [DIV_STAGES];
  logic [NUM_AXES-1:0][Q_W-1:0] dv_q   [DIV_STAGES];
  sbf_flags_t                   dv_fl  [DIV_STAGES];
  logic [MAG_W-1:0]             dv_mag [1:DIV_LAST];
  logic [LEN_W-1:0]             e_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sr_v[SQ_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_len[0] <= len_c;
      dv_rem[0] <= rem0_c;
      dv_q[0]   <= q0_c;
      dv_fl[0]  <= fl0_c;
      e_ext     <= ext_c;
    end
  end

  // Magnitude k * extension, formed alongside the first fraction bit.
  logic [63:0] kext_c;
  assign kext_c = {33'd0, spring_const} * {31'd0, e_ext};

  // Remaining divider stages: one fraction bit of |d| / len per stage.
  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_div
    logic [NUM_AXES-1:0][D_W-1:0] rem_n;
    logic [NUM_AXES-1:0][Q_W-1:0] q_n;
    logic [D_W:0]                 rem2 [NUM_AXES];
    logic [NUM_AXES-1:0]          qb;
    logic [MAG_W-1:0]             mag_in;

    if (j == 1) begin : g_mag
      assign mag_in = kext_c[63:FRAC_BITS];
    end else begin : g_carry
      assign mag_in = dv_mag[j-1];
    end

    always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
        rem2[i]  = {dv_rem[j-1][i], 1'b0};
        qb[i]    = rem2[i] >= {1'b0, dv_len[j-1]};
        rem_n[i] = qb[i] ? D_W'(rem2[i] - {1'b0, dv_len[j-1]}) : rem2[i][D_W-1:0];
        q_n[i]   = {dv_q[j-1][i][Q_W-2:0], qb[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (en) begin
        dv_v[j] <= dv_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_len[j] <= dv_len[j-1];
        dv_rem[j] <= rem_n;
        dv_q[j]   <= q_n;
        dv_fl[j]  <= dv_fl[j-1];
        dv_mag[j] <= mag_in;
      end
    end
  end

  // Product stage: magnitude times each unit vector component.
  logic              pr_v;
  logic [PROD_W-1:0] pr_p [NUM_AXES];
  sbf_flags_t        pr_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v <= 1'b0;
    end else if (en) begin
      pr_v <= dv_v[DIV_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_fl <= dv_fl[DIV_LAST];
      for (int i = 0; i < NUM_AXES; i++) begin
        pr_p[i] <= {{Q_W{1'b0}}, dv_mag[DIV_LAST]} * {{MAG_W{1'b0}}, dv_q[DIV_LAST][i]};
      end
    end
  end

  // Output stage: scale down, saturate, apply the direction and special cases.
  logic [SHR_W-1:0] sh_c    [NUM_AXES];
  logic [SHR_W-1:0] limit_c [NUM_AXES];
  logic [SHR_W-1:0] m_c     [NUM_AXES];
  logic [31:0]      f_c     [NUM_AXES];
  logic             negf_c  [NUM_AXES];
  sbf_out_t         out_c;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sh_c[i]    = pr_p[i][PROD_W-1:FRAC_BITS];
      negf_c[i]  = (pr_fl.dpos[i] && !pr_fl.negx) || (pr_fl.dneg[i] && pr_fl.negx);
      limit_c[i] = negf_c[i] ? SHR_W'(33'h0_8000_0000) : SHR_W'(33'h0_7FFF_FFFF);
      m_c[i]     = (sh_c[i] > limit_c[i]) ? limit_c[i] : sh_c[i];
      if (pr_fl.slack || pr_fl.zero) begin
        f_c[i] = '0;
      end else begin
        f_c[i] = negf_c[i] ? (~m_c[i][31:0] + 1'b1) : m_c[i][31:0];
      end
    end
    out_c.force_x = f_c[0];
    out_c.force_y = f_c[1];
    out_c.force_z = f_c[2];
    out_c.applied = !pr_fl.slack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= pr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= out_c;
    end
  end

  // A slack bungee never carries a force.
  `SBF_ASSERT(a_slack_no_force, res_valid && !res_data.applied,
    res_data.force_x == 0 && res_data.force_y == 0 && res_data.force_z == 0,
    "slack bungee result carries a force")

  // The unit vector component never exceeds one once the length is nonzero.
  `SBF_ASSERT(a_unit_range, dv_v[DIV_LAST] && !dv_fl[DIV_LAST].zero,
    dv_q[DIV_LAST][0] <= (Q_W'(1) << FRAC_BITS) &&
    dv_q[DIV_LAST][1] <= (Q_W'(1) << FRAC_BITS) &&
    dv_q[DIV_LAST][2] <= (Q_W'(1) << FRAC_BITS),
    "unit vector component above one")

  // A zero length can only come from a zero separation.
  `SBF_ASSERT(a_zero_len, dv_v[0] && dv_fl[0].zero,
    dv_fl[0].dpos == '0 && dv_fl[0].dneg == '0,
    "zero length with nonzero separation")

  // A frozen pipeline keeps the root it has formed.
  `SBF_ASSERT_NEXT(a_sqrt_hold, sr_v[SQ_LAST] && !en,
    sr_v[SQ_LAST] && $stable(sr_res[SQ_LAST]),
    "square root stage changed while stalled")

endmodule
`default_nettype wire

FILE: tb/tb_spring_bungee_force.sv
// Self-checking testbench of the spring and bungee force pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_spring_bungee_force;
  import sbf_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 39;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic src_valid = 1'b0;
  logic src_stall;
  sbf_in_t src_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  sbf_out_t res_data;

  spring_bungee_force #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  always #4 clk = ~clk;

  // Our own copy of the register file, updated whenever a write is issued.
  logic [30:0] k_reg, rest_reg;
  logic bungee_reg, anchored_reg;
  logic signed [31:0] anc_x, anc_y, anc_z;

  sbf_out_t force_queue[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_slack = 0;
  int n_sat = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  // Computes the expected force for one transaction from the local registers.
  function automatic sbf_out_t spring_force(sbf_in_t t);
    logic signed [32:0] d[3];
    logic [32:0] ad[3];
    logic [65:0] sq;
    logic [69:0] cand_sq;
    logic [34:0] len, cand;
    logic [34:0] ext;
    logic [63:0] mag;
    logic [63:0] u;
    logic [127:0] p;
    logic [63:0] lim, m;
    logic neg, negative;
    logic signed [31:0] oth[3];
    logic signed [31:0] pos[3];
    logic [31:0] f[3];
    sbf_out_t r;
    pos[0] = t.pos_x; pos[1] = t.pos_y; pos[2] = t.pos_z;
    if (anchored_reg) begin
      oth[0] = anc_x; oth[1] = anc_y; oth[2] = anc_z;
    end else begin
      oth[0] = t.other_x; oth[1] = t.other_y; oth[2] = t.other_z;
    end
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 33'(pos[i]) - 33'(oth[i]);
      ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sq = sq + 66'(ad[i]) * 66'(ad[i]);
    end
    // Integer square root, one bit at a time from the top.
    len = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = len | (35'd1 << b);
      cand_sq = 70'(cand) * 70'(cand);
      if (cand_sq <= 70'(sq)) len = cand;
    end
    r = '0;
    r.applied = 1'b1;
    if (bungee_reg && len <= 35'(rest_reg)) begin
      r.applied = 1'b0;
      return r;
    end
    if (len == 0) return r;
    if (len >= 35'(rest_reg)) begin
      ext = len - 35'(rest_reg);
      neg = 1'b0;
    end else begin
      ext = 35'(rest_reg) - len;
      neg = anchored_reg;
    end
    mag = (64'(k_reg) * 64'(ext)) >> FRAC;
    for (int i = 0; i < 3; i++) begin
      u = (64'(ad[i]) << FRAC) / 64'(len);
      p = (128'(mag) * 128'(u)) >> FRAC;
      negative = (d[i] > 0 && !neg) || (d[i] < 0 && neg);
      lim = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
      m = (p > 128'(lim)) ? lim : p[63:0];
      f[i] = negative ? 32'(-m) : 32'(m);
    end
    r.force_x = f[0]; r.force_y = f[1]; r.force_z = f[2];
    return r;
  endfunction

  // Writes one register through the APB port and mirrors it locally.
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SPRING_CONST:  k_reg = val[30:0];
      REG_REST_LENGTH:   rest_reg = val[30:0];
      REG_BUNGEE_MODE:   bungee_reg = val[0];
      REG_ANCHORED_MODE: anchored_reg = val[0];
      REG_ANCHOR_X:      anc_x = val;
      REG_ANCHOR_Y:      anc_y = val;
      REG_ANCHOR_Z:      anc_z = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] k, logic [31:0] rl, logic bm, logic am,
                            logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
    reg_write(REG_SPRING_CONST, k);
    reg_write(REG_REST_LENGTH, rl);
    reg_write(REG_BUNGEE_MODE, {31'd0, bm});
    reg_write(REG_ANCHORED_MODE, {31'd0, am});
    reg_write(REG_ANCHOR_X, ax);
    reg_write(REG_ANCHOR_Y, ay);
    reg_write(REG_ANCHOR_Z, az);
  endtask

  // Offers one transaction and holds it until the block takes it. The
  // prediction is queued at the accepting edge, ahead of any result.
  task automatic send_item(sbf_in_t t);
    src_valid <= 1'b1;
    src_data <= t;
    do @(posedge clk); while (src_stall);
    force_queue.insert(force_queue.size(), spring_force(t));
  endtask

  task automatic drop_valid();
    src_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (force_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Small coordinates keep most forces in range; a share of full-range ones
  // drives the saturation and the wide square root.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      default: return 32'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic sbf_in_t rand_item();
    sbf_in_t t;
    t.pos_x = rand_coord(); t.pos_y = rand_coord(); t.pos_z = rand_coord();
    t.other_x = rand_coord(); t.other_y = rand_coord(); t.other_z = rand_coord();
    if ($urandom_range(0, 15) == 0) t.other_x = t.pos_x;
    if ($urandom_range(0, 15) == 0) begin
      t.other_y = t.pos_y; t.other_z = t.pos_z;
    end
    return t;
  endfunction

  // Sends n random transactions in bursts, most followed by a random gap.
  task automatic random_burst(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_item(rand_item());
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        drop_valid();
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    drop_valid();
  endtask

  // Directed rows: a transaction and, where it is plain, the expected force.
  typedef struct {
    sbf_in_t item;
    bit has_exp;
    sbf_out_t exp_res;
  } dir_row_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;

  dir_row_t dir_rows[$];

  function automatic sbf_in_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                 logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
    sbf_in_t t;
    t.pos_x = px; t.pos_y = py; t.pos_z = pz;
    t.other_x = ox; t.other_y = oy; t.other_z = oz;
    return t;
  endfunction

  // Adds one row at the end of the directed table.
  function automatic void add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Result side: a stall pattern of its own, plus one long hold-off.
  initial begin
    int cnt;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        res_stall <= 1'b1;
        cnt++;
        if (cnt >= 3 * LATENCY) begin
          hold_long = 1'b0;
          cnt = 0;
        end
      end else if (stim_done) begin
        res_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: res_stall <= 1'b1;
          2: res_stall <= ($urandom_range(0, 1) == 1);
          default: res_stall <= 1'b0;
        endcase
      end
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    sbf_out_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      if (force_queue.size() == 0) begin
        $error("result with no transaction waiting: %h", res_data);
        n_errors++;
      end else begin
        exp_r = force_queue.pop_front();
        n_checked++;
        if (!exp_r.applied) n_slack++;
        if (exp_r.force_x == MAXP || exp_r.force_x == MINN) n_sat++;
        if (res_data.force_x !== exp_r.force_x) begin
          $error("force_x expected %h actual %h", exp_r.force_x, res_data.force_x);
          n_errors++;
        end
        if (res_data.force_y !== exp_r.force_y) begin
          $error("force_y expected %h actual %h", exp_r.force_y, res_data.force_y);
          n_errors++;
        end
        if (res_data.force_z !== exp_r.force_z) begin
          $error("force_z expected %h actual %h", exp_r.force_z, res_data.force_z);
          n_errors++;
        end
        if (res_data.applied !== exp_r.applied) begin
          $error("applied expected %b actual %b", exp_r.applied, res_data.applied);
          n_errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases across settings.
  initial begin
    sbf_out_t zero_app, slack_r, pred;
    zero_app = '0; zero_app.applied = 1'b1;
    slack_r = '0;
    k_reg = 31'h1_0000; rest_reg = 31'h1_0000;
    bungee_reg = 1'b0; anchored_reg = 1'b0;
    anc_x = '0; anc_y = '0; anc_z = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values: k = 1, rest = 1, plain spring. Coincident ends give zero.
    add_row('{mk(0, 0, 0, 0, 0, 0), 1, zero_app});
    // Exactly rest length apart: zero extension.
    add_row('{mk(ONE, 0, 0, 0, 0, 0), 1, zero_app});
    // Two units along x, then along y: pulled back by one unit.
    add_row('{mk(2 * ONE, 0, 0, 0, 0, 0), 1,
              '{force_x: -32'sh1_0000, force_y: 0, force_z: 0, applied: 1}});
    add_row('{mk(0, 0, 0, 0, 2 * ONE, 0), 1,
              '{force_x: 0, force_y: 32'sh1_0000, force_z: 0, applied: 1}});
    // Field extremes, including the widest separation on every axis; then small ones.
    add_row('{mk(MAXP, MAXP, MAXP, MINN, MINN, MINN), 0, zero_app});
    add_row('{mk(MINN, MINN, MINN, MAXP, MAXP, MAXP), 0, zero_app});
    add_row('{mk(MAXP, MINN, 0, 0, MAXP, MINN), 0, zero_app});
    add_row('{mk(32'hFFFF_FFFF, 1, 32'h5555_5555, 32'hAAAA_AAAA, 0, 1),
              0, zero_app});
    add_row('{mk(1, 0, 0, 0, 0, 0), 0, zero_app});
    add_row('{mk(ONE / 2, 0, 0, 0, 0, 0), 0, zero_app});
    foreach (dir_rows[i]) begin
      pred = spring_force(dir_rows[i].item);
      if (dir_rows[i].has_exp && pred !== dir_rows[i].exp_res) begin
        $error("directed row %0d: table %h, prediction %h", i,
               dir_rows[i].exp_res, pred);
        n_errors++;
      end
      send_item(dir_rows[i].item);
    end
    drop_valid();
    wait_drained();

    // Bungee, two ends: slack inside rest, force beyond it.
    set_config(ONE, 3 * ONE, 1'b1, 1'b0, 0, 0, 0);
    send_item(mk(ONE, ONE, 0, 0, 0, 0));
    force_queue[$] = force_queue[$];
    send_item(mk(0, 0, 0, 0, 0, 0));
    send_item(mk(10 * ONE, 0, 0, 0, 0, 0));
    send_item(mk(MAXP, 0, 0, MINN, 0, 0));
    drop_valid();
    wait_drained();

    // Anchored spring at extreme settings: stretched far beyond rest, and at the anchor.
    set_config(MAXP, MAXP, 1'b0, 1'b1, MINN, MAXP, ONE);
    send_item(mk(0, 0, ONE, 5, 7, 9));
    send_item(mk(MINN, MAXP, ONE, 0, 0, 0));
    send_item(mk(MAXP, MINN, MAXP, 0, 0, 0));
    drop_valid();
    wait_drained();

    // Random phases over a spread of settings, the extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(ONE, ONE, 1'b0, 1'b0, 0, 0, 0);
        1: set_config(0, 0, 1'b0, 1'b1, 0, 0, 0);
        2: set_config(MAXP, 0, 1'b1, 1'b0, 0, 0, 0);
        3: set_config(32'hFFFF_FFFF, MAXP, 1'b1, 1'b1, MAXP, MINN, 32'hFFFF_FFFF);
        default: set_config($urandom_range(0, 8 << 16) | ($urandom() & 32'h8000_0000),
                            $urandom_range(0, 8 << 16), 1'($urandom()), 1'($urandom()),
                            rand_coord(), rand_coord(), rand_coord());
      endcase
      if (ph == 2) begin
        // Long receiver hold-off while items keep coming: the pipeline fills.
        hold_long = 1'b1;
      end
      random_burst(70);
      // The sender waits for every prediction to be met before reconfiguring.
      wait_drained();
    end

    stim_done = 1'b1;
    wait_drained();
    $display("Checked %0d force results (%0d slack bungee, %0d saturated on x)",
             n_checked, n_slack, n_sat);
    $display("over spring, bungee, anchored and free-end settings with random stalls.");
    if (n_errors == 0 && force_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
